FILE: hw/rtl/svslew_pkg.sv
package svslew_pkg;

   // Request codes carried by req_type.
   typedef enum logic [2:0] {
      REQ_TICK        = 3'd0,
      REQ_SET_ANGLE   = 3'd1,
      REQ_SET_PULSE   = 3'd2,
      REQ_MODE_POT    = 3'd3,
      REQ_MODE_REMOTE = 3'd4,
      REQ_QUERY       = 3'd5
   } req_code_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_DEADBAND = 1'b0,
      CSR_SLEW     = 1'b1
   } csr_index_type;

   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 8;

   localparam logic [7:0]  AngleMax     = 8'd180;
   localparam logic [11:0] AngleMaxCmd  = 12'd180;
   localparam logic [11:0] PulseMinUs   = 12'd500;
   localparam logic [11:0] PulseMaxUs   = 12'd2500;
   localparam logic [7:0]  AngleReset   = 8'd90;
   localparam logic [12:0] PulseReset   = 13'd3000;
   localparam logic [7:0]  DeadbandReset = 8'd2;
   localparam logic [7:0]  SlewReset     = 8'd2;

   // floor(pot * 180 / 1023) == (pot * PotRecip) >> 20 for every 10-bit pot.
   localparam logic [17:0] PotRecip  = 18'd184501;
   // floor(v * 180 / 2000) == (v * RawRecip) >> 20 for v up to 2000.
   localparam logic [16:0] RawRecip  = 17'd94372;
   // floor(deg * 2000 / 180) == (deg * TicksRecip) >> 17 for deg up to 180.
   localparam logic [20:0] TicksRecip = 21'd1456400;

   // One request as it sits in the input stage, with its degree argument
   // already scaled (pot reading for a tick, raw pulse for a set pulse).
   typedef struct packed {
      req_code_type kind;
      logic [11:0]  cmd;
      logic [7:0]   deg;
   } item_type;

   // Servo compare value in half-microsecond ticks for an angle.
   function automatic logic [12:0] angle_to_ticks(input logic [7:0] deg);
      logic [28:0] prod;
      logic [11:0] us;
      prod = 29'(deg) * 29'(TicksRecip);
      us   = 12'(prod[27:17]) + PulseMinUs;
      return {us, 1'b0};
   endfunction

endpackage

FILE: hw/rtl/svslew_prep.sv
module svslew_prep
   import svslew_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [9:0]  req_pot_value,
   input  logic [11:0] req_command_value,
   input  logic        item_taken,
   output logic        item_valid,
   output item_type    item
);

   logic        valid_ff;
   logic        valid_in;
   item_type    item_ff;
   item_type    item_in;
   logic [27:0] pot_prod;
   logic [27:0] raw_prod;
   logic [10:0] raw_offset;
   logic        req_transfer;

   assign req_ready    = !valid_ff || item_taken;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      pot_prod   = 28'(req_pot_value) * 28'(PotRecip);
      raw_offset = 11'(req_command_value - PulseMinUs);
      raw_prod   = 28'(raw_offset) * 28'(RawRecip);

      item_in.kind = req_code_type'(req_type);
      item_in.cmd  = req_command_value;
      // Only a tick uses the pot angle; only a set pulse uses the derived angle.
      if (req_code_type'(req_type) == REQ_TICK) begin
         item_in.deg = pot_prod[27:20];
      end else begin
         item_in.deg = raw_prod[27:20];
      end

      if (req_transfer) begin
         valid_in = 1'b1;
      end else if (item_taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_transfer) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/svslew_core.sv
module svslew_core
   import svslew_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     item_valid,
   input  item_type                 item,
   output logic                     item_taken,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [12:0]              rsp_pulse_ticks,
   output logic [7:0]               rsp_angle_now,
   output logic                     rsp_remote_mode,
   output logic                     rsp_error_flag
);

   logic [7:0]  deadband_ff;
   logic [7:0]  slew_ff;
   logic [7:0]  current_ff;
   logic [7:0]  current_in;
   logic [7:0]  target_ff;
   logic [7:0]  target_in;
   logic        mode_ff;
   logic        mode_in;
   logic [12:0] pulse_ff;
   logic [12:0] pulse_in;
   logic        error_ff;
   logic        error_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;

   logic [7:0]  pot_diff;
   logic [7:0]  target_tick;
   logic [7:0]  slew_diff;
   logic [7:0]  slew_move;
   logic [7:0]  current_tick;
   logic [12:0] angle_ticks;

   // The state registers double as the result register, so an item is
   // applied only when the previous result has been or is being taken.
   assign item_taken = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pot_diff = (item.deg > target_ff) ? item.deg - target_ff : target_ff - item.deg;
      if (!mode_ff && (pot_diff >= deadband_ff)) begin
         target_tick = item.deg;
      end else begin
         target_tick = target_ff;
      end

      slew_diff = (current_ff > target_tick) ? current_ff - target_tick
                                             : target_tick - current_ff;
      slew_move = (slew_diff > slew_ff) ? slew_ff : slew_diff;
      if (current_ff < target_tick) begin
         current_tick = current_ff + slew_move;
      end else begin
         current_tick = current_ff - slew_move;
      end

      current_in = current_ff;
      target_in  = target_ff;
      mode_in    = mode_ff;
      pulse_in   = pulse_ff;
      error_in   = error_ff;

      if (item_taken) begin
         error_in = 1'b0;
         case (item.kind)
            REQ_TICK: begin
               target_in  = target_tick;
               current_in = current_tick;
            end
            REQ_SET_ANGLE: begin
               if (item.cmd <= AngleMaxCmd) begin
                  target_in  = item.cmd[7:0];
                  current_in = item.cmd[7:0];
                  mode_in    = 1'b1;
               end else begin
                  error_in = 1'b1;
               end
            end
            REQ_SET_PULSE: begin
               if ((item.cmd >= PulseMinUs) && (item.cmd <= PulseMaxUs)) begin
                  target_in  = item.deg;
                  current_in = item.deg;
                  mode_in    = 1'b1;
               end else begin
                  error_in = 1'b1;
               end
            end
            REQ_MODE_POT: begin
               mode_in = 1'b0;
            end
            REQ_MODE_REMOTE: begin
               mode_in = 1'b1;
            end
            REQ_QUERY: begin
            end
            default: begin
               error_in = 1'b1;
            end
         endcase
      end

      angle_ticks = angle_to_ticks(current_in);
      if (item_taken && !error_in) begin
         if (item.kind == REQ_SET_PULSE) begin
            pulse_in = {item.cmd, 1'b0};
         end else if ((item.kind == REQ_TICK) || (item.kind == REQ_SET_ANGLE)) begin
            pulse_in = angle_ticks;
         end
      end

      if (item_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DeadbandReset;
         slew_ff      <= SlewReset;
         current_ff   <= AngleReset;
         target_ff    <= AngleReset;
         mode_ff      <= 1'b0;
         pulse_ff     <= PulseReset;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         current_ff   <= current_in;
         target_ff    <= target_in;
         mode_ff      <= mode_in;
         pulse_ff     <= pulse_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DEADBAND: begin
                  deadband_ff <= csr_wdata;
               end
               CSR_SLEW: begin
                  slew_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_ticks = pulse_ff;
   assign rsp_angle_now   = current_ff;
   assign rsp_remote_mode = mode_ff;
   assign rsp_error_flag  = error_ff;

`ifndef SYNTH
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      item_taken |=> rsp_valid_ff)
      else $error("applied item produced no result");

   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      (current_ff <= AngleMax) && (target_ff <= AngleMax))
      else $error("angle state out of range");

   a_pulse_in_range: assert property (@(posedge clock) disable iff (reset)
      (pulse_ff >= 13'd1000) && (pulse_ff <= 13'd5000))
      else $error("pulse state out of range");

   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (item_taken && error_in) |=> ((current_ff == $past(current_ff))
         && (pulse_ff == $past(pulse_ff)) && (mode_ff == $past(mode_ff))))
      else $error("rejected request changed the state");

   a_held_result_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(current_ff) && $stable(pulse_ff))
      else $error("state moved while a result was waiting");
`endif

endmodule

FILE: hw/rtl/servo_position_slew_controller_top.sv
// Servo slew-rate limiter with deadband. Every request on the req_ channel
// (tick with a pot reading, set angle, set raw pulse, select mode, query)
// returns exactly one result on the rsp_ channel holding the compare value,
// the angle and the mode after the request, plus an error flag for a
// rejected value or an unknown request code. The pot reading or raw pulse
// is scaled to degrees into the input register; a request is applied to the
// state once the previous result has been or is being taken, and the state
// registers drive the result directly. A new request is taken every cycle
// as long as results are taken. The user must write the deadband and slew
// step through the csr_ port only while idle, which is not enforced.
module servo_position_slew_controller_top
   import svslew_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic [9:0]               req_pot_value,
   input  logic [11:0]              req_command_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [12:0]              rsp_pulse_ticks,
   output logic [7:0]               rsp_angle_now,
   output logic                     rsp_remote_mode,
   output logic                     rsp_error_flag
);

   logic     item_valid;
   logic     item_taken;
   item_type item;

   svslew_prep u_prep (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_pot_value     (req_pot_value),
      .req_command_value (req_command_value),
      .item_taken        (item_taken),
      .item_valid        (item_valid),
      .item              (item)
   );

   svslew_core u_core (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .item_valid      (item_valid),
      .item            (item),
      .item_taken      (item_taken),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pulse_ticks (rsp_pulse_ticks),
      .rsp_angle_now   (rsp_angle_now),
      .rsp_remote_mode (rsp_remote_mode),
      .rsp_error_flag  (rsp_error_flag)
   );

endmodule

FILE: bench/tb_servo_position_slew_controller_top.sv
`timescale 1ns / 100ps

module tb_servo_position_slew_controller_top;
   import svslew_pkg::*;

   // Request codes outside the defined set; the block must flag them.
   localparam logic [2:0] ReqSpareLow  = 3'd6;
   localparam logic [2:0] ReqSpareHigh = 3'd7;
   localparam int         PhaseCount   = 8;
   localparam int         PhaseItems   = 215;

   class servo_state_scoreboard;
      typedef struct packed {
         logic [12:0] pulse;
         logic [7:0]  angle;
         logic        remote;
         logic        err;
      } servo_result_type;

      int unsigned      cur_angle;
      int unsigned      tgt_angle;
      int unsigned      pulse_reg;
      bit               remote;
      int unsigned      deadband;
      int unsigned      slew;
      int               fails;
      servo_result_type expected_states[$];

      function new();
         cur_angle = 90;
         tgt_angle = 90;
         pulse_reg = 3000;
         remote    = 1'b0;
         deadband  = 2;
         slew      = 2;
         fails     = 0;
      endfunction

      function void set_limits(int unsigned db, int unsigned sl);
         deadband = db;
         slew     = sl;
      endfunction

      function int pending();
         return expected_states.size();
      endfunction

      function int unsigned degrees_to_ticks(int unsigned deg);
         return (500 + (2000 * deg) / 180) * 2;
      endfunction

      // Applies one accepted request to the predicted servo state and queues
      // the state the block must report for it.
      function void apply_request(logic [2:0] kind, logic [9:0] pot, logic [11:0] cmd);
         int unsigned      pot_deg;
         int unsigned      gap;
         bit               err;
         servo_result_type res;
         err = 1'b0;
         case (kind)
            REQ_TICK: begin
               if (!remote) begin
                  pot_deg = (int'(pot) * 180) / 1023;
                  gap = (pot_deg > tgt_angle) ? pot_deg - tgt_angle : tgt_angle - pot_deg;
                  if (gap >= deadband) tgt_angle = pot_deg;
               end
               if (cur_angle < tgt_angle) begin
                  gap = tgt_angle - cur_angle;
                  cur_angle += (gap > slew) ? slew : gap;
               end else if (cur_angle > tgt_angle) begin
                  gap = cur_angle - tgt_angle;
                  cur_angle -= (gap > slew) ? slew : gap;
               end
               pulse_reg = degrees_to_ticks(cur_angle);
            end
            REQ_SET_ANGLE: begin
               if (cmd <= 180) begin
                  cur_angle = 32'(cmd);
                  tgt_angle = 32'(cmd);
                  remote    = 1'b1;
                  pulse_reg = degrees_to_ticks(32'(cmd));
               end else begin
                  err = 1'b1;
               end
            end
            REQ_SET_PULSE: begin
               if (cmd >= 500 && cmd <= 2500) begin
                  cur_angle = ((int'(cmd) - 500) * 180) / 2000;
                  tgt_angle = cur_angle;
                  remote    = 1'b1;
                  pulse_reg = int'(cmd) * 2;
               end else begin
                  err = 1'b1;
               end
            end
            REQ_MODE_POT:    remote = 1'b0;
            REQ_MODE_REMOTE: remote = 1'b1;
            REQ_QUERY: ;
            default:         err = 1'b1;
         endcase
         res.pulse  = pulse_reg[12:0];
         res.angle  = cur_angle[7:0];
         res.remote = remote;
         res.err    = err;
         expected_states.push_back(res);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [12:0] pulse, logic [7:0] angle, logic rm, logic err);
         servo_result_type want;
         if (expected_states.size() == 0) begin
            fails++;
            $display("%0t: unexpected result, expected none actual pulse %0d angle %0d",
                     $time, pulse, angle);
            return;
         end
         want = expected_states.pop_front();
         compare_field("pulse_ticks", 16'(want.pulse), 16'(pulse));
         compare_field("angle_now", 16'(want.angle), 16'(angle));
         compare_field("remote_mode", 16'(want.remote), 16'(rm));
         compare_field("error_flag", 16'(want.err), 16'(err));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   logic                     req_valid;
   logic                     req_ready;
   logic [2:0]               req_type;
   logic [9:0]               req_pot_value;
   logic [11:0]              req_command_value;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [12:0]              rsp_pulse_ticks;
   logic [7:0]               rsp_angle_now;
   logic                     rsp_remote_mode;
   logic                     rsp_error_flag;

   servo_state_scoreboard board;
   int                    gap_pct;
   int                    stall_pct;
   int                    stall_left;
   int                    last_pot;

   servo_position_slew_controller_top DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_pot_value     (req_pot_value),
      .req_command_value (req_command_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pulse_ticks   (rsp_pulse_ticks),
      .rsp_angle_now     (rsp_angle_now),
      .rsp_remote_mode   (rsp_remote_mode),
      .rsp_error_flag    (rsp_error_flag)
   );

   always #10 clock = ~clock;

   // Result side backpressure: ready drops in bursts whose odds the phase sets.
   always @(posedge clock) begin
      if (stall_pct == 0) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Outputs are sampled at the falling edge, clear of any update.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_pulse_ticks, rsp_angle_now, rsp_remote_mode, rsp_error_flag);
   end

   // Called at a rising edge; returns at the edge where the transfer happens.
   task automatic send_request(input logic [2:0] kind, input logic [9:0] pot,
                               input logic [11:0] cmd);
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_pot_value     <= pot;
      req_command_value <= cmd;
      do @(negedge clock); while (!req_ready);
      board.apply_request(kind, pot, cmd);
      @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_limits(input int unsigned db, input int unsigned sl);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEADBAND;
      csr_wdata <= db[7:0];
      @(posedge clock);
      csr_index <= CSR_SLEW;
      csr_wdata <= sl[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_limits(db, sl);
   endtask

   // Mostly pot ticks, which carry the deadband and slew behavior; commands
   // and mode changes are mixed in, with out of range values now and then.
   task automatic random_request();
      int          pick;
      int          pot;
      logic [2:0]  kind;
      logic [11:0] cmd;
      pick = $urandom_range(0, 99);
      pot  = $urandom_range(0, 1023);
      cmd  = 12'($urandom_range(0, 4095));
      if (pick < 55) begin
         kind = REQ_TICK;
         case ($urandom_range(0, 9))
            0: pot = 0;
            1: pot = 1023;
            2, 3: begin
               pot = last_pot + $urandom_range(0, 24) - 12;
               if (pot < 0) pot = 0;
               if (pot > 1023) pot = 1023;
            end
            default: ;
         endcase
         last_pot = pot;
      end else if (pick < 65) begin
         kind = REQ_SET_ANGLE;
         cmd  = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 180))
                                             : 12'($urandom_range(181, 4095));
      end else if (pick < 73) begin
         kind = REQ_SET_PULSE;
         case ($urandom_range(0, 9))
            0:       cmd = 12'($urandom_range(0, 499));
            1:       cmd = 12'($urandom_range(2501, 4095));
            default: cmd = 12'($urandom_range(500, 2500));
         endcase
      end else if (pick < 85) begin
         kind = REQ_MODE_POT;
      end else if (pick < 90) begin
         kind = REQ_MODE_REMOTE;
      end else if (pick < 96) begin
         kind = REQ_QUERY;
      end else begin
         kind = $urandom_range(0, 1) ? ReqSpareHigh : ReqSpareLow;
      end
      send_request(kind, pot[9:0], cmd);
   endtask

   initial begin
      int unsigned deadband_plan[PhaseCount];
      int unsigned slew_plan[PhaseCount];
      board             = new();
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_DEADBAND;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_type          = REQ_QUERY;
      req_pot_value     = '0;
      req_command_value = '0;
      gap_pct           = 0;
      stall_pct         = 0;
      stall_left        = 0;
      last_pot          = 512;
      deadband_plan     = '{0, 180, 5, 0, 255, 1, 0, 2};
      slew_plan         = '{1, 180, 3, 0, 255, 10, 1, 2};
      deadband_plan[6]  = $urandom_range(0, 180);
      slew_plan[6]      = $urandom_range(1, 180);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run with the reset deadband and slew step.
      send_request(REQ_QUERY, 10'd0, 12'd0);
      send_request(REQ_TICK, 10'd0, 12'd4095);
      send_request(REQ_TICK, 10'd1023, 12'd0);
      send_request(REQ_TICK, 10'd511, 12'd0);
      // Pot reading within the deadband of the target leaves it alone.
      send_request(REQ_TICK, 10'd517, 12'd0);
      send_request(REQ_SET_ANGLE, 10'd1023, 12'd0);
      send_request(REQ_SET_ANGLE, 10'd0, 12'd180);
      send_request(REQ_SET_ANGLE, 10'd0, 12'd181);
      send_request(REQ_SET_ANGLE, 10'd0, 12'd4095);
      send_request(REQ_SET_PULSE, 10'd0, 12'd499);
      send_request(REQ_SET_PULSE, 10'd0, 12'd500);
      send_request(REQ_SET_PULSE, 10'd0, 12'd2500);
      send_request(REQ_SET_PULSE, 10'd0, 12'd2501);
      send_request(REQ_SET_PULSE, 10'd0, 12'd0);
      send_request(REQ_SET_PULSE, 10'd0, 12'd1500);
      send_request(REQ_TICK, 10'd1023, 12'd0);
      send_request(REQ_MODE_POT, 10'd0, 12'd0);
      send_request(REQ_TICK, 10'd0, 12'd0);
      send_request(REQ_MODE_REMOTE, 10'd0, 12'd0);
      send_request(REQ_TICK, 10'd0, 12'd0);
      send_request(REQ_MODE_POT, 10'd0, 12'd0);
      send_request(ReqSpareLow, 10'd1023, 12'd4095);
      send_request(ReqSpareHigh, 10'd0, 12'd0);
      send_request(REQ_QUERY, 10'd0, 12'd0);
      send_request(REQ_TICK, 10'd1023, 12'd4095);
      drain_results();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         write_limits(deadband_plan[phase], slew_plan[phase]);
         if (phase == PhaseCount - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (phase == 0) begin
            gap_pct   = 30;
            stall_pct = 30;
         end else begin
            gap_pct   = $urandom_range(0, 3) * 15;
            stall_pct = $urandom_range(0, 3) * 15;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
               idle_sender($urandom_range(1, 12));
            random_request();
            if ($urandom_range(0, 199) == 0)
               drain_results();
         end
         drain_results();
      end

      repeat (6) @(posedge clock);
      if (board.fails == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
